/* hdl/lkvc_pkg.sv */
// Shared types and constants of the LRU key/value cache.
package lkvc_pkg;

	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [CAP_W-1:0] cap_t;

	// Capacity after reset.
	localparam cap_t CAP_RESET = 5'd16;
	// Read value returned by a get that misses.
	localparam value_t MISS_VALUE = {VAL_W{1'b1}};

	typedef enum logic {
		MODE_GET = 1'b0,
		MODE_PUT = 1'b1
	} mode_t;

	// Entry update command from the lookup to the store.
	typedef struct packed {
		logic en;          // touch the selected slot (make it most recent)
		logic insert;      // slot is a free one: mark valid and bump the count
		logic load_key;    // write the item key into the slot
		logic load_value;  // write the item value into the slot
	} upd_t;

endpackage

/* hdl/lkvc_req_if.sv */
// Request channel: one get or put word with valid/ready handshake.
interface lkvc_req_if import lkvc_pkg::*; ();
	logic   valid;
	logic   ready;
	mode_t  mode;
	key_t   key;
	value_t write_value;

	modport source (output valid, output mode, output key, output write_value, input ready);
	modport sink (input valid, input mode, input key, input write_value, output ready);
endinterface

/* hdl/lkvc_rsp_if.sv */
// Response channel: one result word with valid/ready handshake.
interface lkvc_rsp_if import lkvc_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   hit;
	value_t read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink (input valid, input hit, input read_value, output ready);
endinterface

/* hdl/lkvc_store.sv */
// Entry storage: valid bits, keys, values, recency ranks and fill count.
module lkvc_store import lkvc_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CntW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  upd_t                          upd,
	input  logic [IdxW-1:0]               slot,
	input  logic [CntW-1:0]               ref_age,
	input  key_t                          key,
	input  value_t                        value_in,
	output logic [MAX_ENTRIES-1:0]        valid,
	output key_t                          keys [MAX_ENTRIES],
	output value_t                        values [MAX_ENTRIES],
	output logic [IdxW-1:0]               ages [MAX_ENTRIES],
	output logic [CntW-1:0]               count
);
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [IdxW-1:0]        ages_q [MAX_ENTRIES];
	logic [CntW-1:0]        count_q;
	key_t                   keys_q [MAX_ENTRIES];
	value_t                 values_q [MAX_ENTRIES];

	// Touch: selected slot goes to rank 0, every valid slot younger than the
	// reference rank ages by one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				ages_q[i] <= '0;
			end
		end else if (upd.en) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (IdxW'(i) == slot) begin
					ages_q[i] <= '0;
				end else if (valid_q[i] && (CntW'(ages_q[i]) < ref_age)) begin
					ages_q[i] <= ages_q[i] + IdxW'(1);
				end
			end
			if (upd.insert) begin
				valid_q[slot] <= 1'b1;
				count_q       <= count_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && upd.load_key) begin
			keys_q[slot] <= key;
		end
		if (upd.en && upd.load_value) begin
			values_q[slot] <= value_in;
		end
	end

	assign valid  = valid_q;
	assign keys   = keys_q;
	assign values = values_q;
	assign ages   = ages_q;
	assign count  = count_q;

endmodule

/* hdl/lkvc_lookup.sv */
// Parallel key match, free-slot and victim pick, and update decision.
module lkvc_lookup import lkvc_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CntW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                   active,
	input  mode_t                  mode,
	input  key_t                   key,
	input  cap_t                   capacity,
	input  logic [MAX_ENTRIES-1:0] valid,
	input  key_t                   keys [MAX_ENTRIES],
	input  logic [IdxW-1:0]        ages [MAX_ENTRIES],
	input  logic [CntW-1:0]        count,
	output logic                   hit,
	output logic [IdxW-1:0]        found,
	output logic [IdxW-1:0]        slot,
	output logic [CntW-1:0]        ref_age,
	output upd_t                   upd
);
	logic [MAX_ENTRIES-1:0] match;
	logic [IdxW-1:0]        free_idx;
	logic [IdxW-1:0]        victim_idx;
	logic [CntW-1:0]        eff_cap;
	logic [CntW-1:0]        oldest;

	// Zero capacity acts as one; anything above the slot count saturates.
	always_comb begin
		if (capacity == '0) begin
			eff_cap = CntW'(1);
		end else if (int'(capacity) > MAX_ENTRIES) begin
			eff_cap = CntW'(MAX_ENTRIES);
		end else begin
			eff_cap = CntW'(capacity);
		end
	end

	assign oldest = count - CntW'(1);

	// Lowest numbered slot wins in each search.
	always_comb begin
		hit        = 1'b0;
		found      = '0;
		free_idx   = '0;
		victim_idx = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = valid[i] && (keys[i] == key);
		end
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit   = 1'b1;
				found = IdxW'(i);
			end
			if (!valid[i]) begin
				free_idx = IdxW'(i);
			end
			if (valid[i] && (CntW'(ages[i]) == oldest)) begin
				victim_idx = IdxW'(i);
			end
		end
	end

	always_comb begin
		upd     = '0;
		slot    = found;
		ref_age = CntW'(ages[found]);
		if (active) begin
			if (hit) begin
				upd.en         = 1'b1;
				upd.load_value = (mode == MODE_PUT);
			end else if (mode == MODE_PUT) begin
				upd.en         = 1'b1;
				upd.load_key   = 1'b1;
				upd.load_value = 1'b1;
				if (count < eff_cap) begin
					// New slot ranks behind everything, so all valid slots age.
					upd.insert = 1'b1;
					slot       = free_idx;
					ref_age    = count;
				end else begin
					slot    = victim_idx;
					ref_age = oldest;
				end
			end
		end
	end

endmodule

/* hdl/lru_key_value_cache_core.sv */
// Top level of the fully associative LRU key/value cache.
// Fully associative key/value cache with least-recently-used replacement,
// MAX_ENTRIES slots. Each request word is a get or a put; each gives exactly
// one response word, in order. A get that hits returns the stored value and
// makes the entry most recent; a get that misses returns -1 with hit clear.
// A put returns 0 in read_value and hit set when the key was present; it
// overwrites on a hit, fills a free slot while the fill count is below the
// capacity register, and otherwise replaces the least recent entry. The
// capacity register (reset 16) treats 0 as 1 and saturates at MAX_ENTRIES;
// lowering it drops nothing, later put misses just replace. Write it only
// while the cache is idle. Throughput is one request per clock while the
// response side does not stall. The cycle time is set by the single pass
// from the input register to the result register: the parallel key compare
// over all slots, the lowest-index pick, and the rank compares that age the
// other entries. An output register decouples the response side, so a new
// request can enter an empty input stage while a response waits.
module lru_key_value_cache_core import lkvc_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lkvc_req_if.sink    req,
	lkvc_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  cap_t        cfg_data
);
	localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CntW = $clog2(MAX_ENTRIES + 1);

	cap_t   capacity_q;

	// Input stage
	logic   valid_s1;
	mode_t  mode_s1;
	key_t   key_s1;
	value_t wval_s1;

	// Result register
	logic   out_valid_q;
	logic   hit_q;
	value_t read_value_q;

	logic                   adv;
	logic                   active;
	logic                   hit;
	logic [IdxW-1:0]        found;
	logic [IdxW-1:0]        slot;
	logic [CntW-1:0]        ref_age;
	upd_t                   upd;
	logic [MAX_ENTRIES-1:0] valid;
	key_t                   keys [MAX_ENTRIES];
	value_t                 values [MAX_ENTRIES];
	logic [IdxW-1:0]        ages [MAX_ENTRIES];
	logic [CntW-1:0]        count;
	value_t                 read_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	// Advance the input stage whenever the result register is free or drains.
	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv;
	// The state update for the staged word happens on the edge it retires.
	assign active    = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the staged word: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1 <= req.mode;
			key_s1  <= req.key;
			wval_s1 <= req.write_value;
		end
	end

	lkvc_lookup #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_lookup (
		.active   (active),
		.mode     (mode_s1),
		.key      (key_s1),
		.capacity (capacity_q),
		.valid    (valid),
		.keys     (keys),
		.ages     (ages),
		.count    (count),
		.hit      (hit),
		.found    (found),
		.slot     (slot),
		.ref_age  (ref_age),
		.upd      (upd)
	);

	lkvc_store #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.slot     (slot),
		.ref_age  (ref_age),
		.key      (key_s1),
		.value_in (wval_s1),
		.valid    (valid),
		.keys     (keys),
		.values   (values),
		.ages     (ages),
		.count    (count)
	);

	// Puts always read zero; a get reads the stored value or the miss marker.
	always_comb begin
		if (mode_s1 == MODE_PUT) begin
			read_value = '0;
		end else if (hit) begin
			read_value = values[found];
		end else begin
			read_value = MISS_VALUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			hit_q        <= hit;
			read_value_q <= read_value;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.read_value = read_value_q;

`ifndef SYNTHESIS
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid) == int'(count))
		else $error("fill count differs from number of valid slots");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count) <= MAX_ENTRIES)
		else $error("fill count above slot count");

	a_insert_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en && upd.insert |-> !valid[slot])
		else $error("insert targets a slot in use");

	a_insert_bumps_count: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en && upd.insert |=> count == $past(count) + CntW'(1))
		else $error("insert did not bump the fill count");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(key_s1) && $stable(mode_s1))
		else $error("staged word lost while output stalled");
`endif

endmodule
